// ----- rtl/core/mstt_pkg.sv -----
// shared types and constants of the multi-slot timer table
// no dependencies; imported by the interfaces, controller and datapath
package mstt_pkg;

  // payload field widths
  localparam int KIND_W  = 3;
  localparam int SLOT_W  = 4;
  localparam int TIME_W  = 32;
  localparam int FLAGS_W = 2;

  // command codes
  localparam logic [KIND_W-1:0] KIND_INIT  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_START = 3'd1;
  localparam logic [KIND_W-1:0] KIND_STOP  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ARM   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_QUERY = 3'd4;
  localparam logic [KIND_W-1:0] KIND_TICK  = 3'd5;
  localparam logic [KIND_W-1:0] KIND_CHECK = 3'd6;

  // result codes
  localparam logic RES_EXPIRY = 1'b0;
  localparam logic RES_QUERY  = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic cap;    // capture the input beat
    logic exec;   // execute the captured command
    logic rd;     // read slot tables at the scan index
    logic step;   // evaluate scanned slot and advance
    logic flush;  // emit held expiry as the final one
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              out_free;
    logic              hit;
    logic              hold_vld;
    logic              idx_last;
  } dp_stat_t;

endpackage

// ----- rtl/core/mstt_if.sv -----
// valid/ready channel interfaces of the multi-slot timer table
// depends on mstt_pkg for the field widths
interface mstt_in_if;
  import mstt_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [SLOT_W-1:0]  slot;
  logic [TIME_W-1:0]  period;
  logic [FLAGS_W-1:0] init_flags;
  logic               repeat_req;

  modport source (output valid, kind, slot, period, init_flags, repeat_req, input ready);
  modport sink   (input valid, kind, slot, period, init_flags, repeat_req, output ready);
endinterface

interface mstt_out_if;
  import mstt_pkg::*;

  logic              valid;
  logic              ready;
  logic              result_kind;
  logic [SLOT_W-1:0] result_slot;
  logic              stopped;
  logic              last;

  modport source (output valid, result_kind, result_slot, stopped, last, input ready);
  modport sink   (input valid, result_kind, result_slot, stopped, last, output ready);
endinterface

// ----- rtl/core/mstt_ctrl.sv -----
// controller state machine of the multi-slot timer table
// depends on mstt_pkg; drives the datapath through ctrl_cmd_t
module mstt_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mstt_pkg::dp_stat_t   stat,
  output mstt_pkg::ctrl_cmd_t  cmd
);
  import mstt_pkg::*;

  localparam int          ST_W     = 3;
  localparam [ST_W-1:0]   ST_IDLE  = 3'd0;
  localparam [ST_W-1:0]   ST_EXEC  = 3'd1;
  localparam [ST_W-1:0]   ST_RD    = 3'd2;
  localparam [ST_W-1:0]   ST_EV    = 3'd3;
  localparam [ST_W-1:0]   ST_FLUSH = 3'd4;

  logic [ST_W-1:0] state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // a query waits for room in the output register
        if (stat.kind != KIND_QUERY || stat.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = (stat.kind == KIND_CHECK) ? ST_RD : ST_IDLE;
        end
      end
      ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_EV;
      end
      ST_EV: begin
        // a new hit pushes the held one out, which needs room
        if (!(stat.hit && stat.hold_vld && !stat.out_free)) begin
          cmd.step  = 1'b1;
          state_nxt = stat.idx_last ? ST_FLUSH : ST_RD;
        end
      end
      ST_FLUSH: begin
        if (!stat.hold_vld || stat.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/core/mstt_dpath.sv -----
// datapath of the multi-slot timer table: time count, slot tables, scan, output register
// depends on mstt_pkg; sequenced by mstt_ctrl through ctrl_cmd_t
module mstt_dpath #(
  parameter int NUM_SLOTS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mstt_pkg::ctrl_cmd_t           cmd,
  output mstt_pkg::dp_stat_t            stat,
  input  logic [mstt_pkg::KIND_W-1:0]   in_kind,
  input  logic [mstt_pkg::SLOT_W-1:0]   in_slot,
  input  logic [mstt_pkg::TIME_W-1:0]   in_period,
  input  logic [mstt_pkg::FLAGS_W-1:0]  in_init_flags,
  input  logic                          in_repeat_req,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_result_kind,
  output logic [mstt_pkg::SLOT_W-1:0]   out_result_slot,
  output logic                          out_stopped,
  output logic                          out_last
);
  import mstt_pkg::*;

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // captured command
  logic [KIND_W-1:0]  cmd_kind_r;
  logic [SLOT_W-1:0]  cmd_slot_r;
  logic [TIME_W-1:0]  cmd_period_r;
  logic [FLAGS_W-1:0] cmd_flags_r;
  logic               cmd_rep_r;

  // slot state
  logic [TIME_W-1:0]    now_r;
  logic [NUM_SLOTS-1:0] act_r, per_r, reg_r;
  logic [NUM_SLOTS-1:0] dl_vld_r, rl_vld_r;
  logic [TIME_W-1:0]    dl_mem [NUM_SLOTS];
  logic [TIME_W-1:0]    rl_mem [NUM_SLOTS];
  logic [TIME_W-1:0]    dl_rd_r, rl_rd_r;

  // scan state
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] hold_r;
  logic             hold_vld_r;

  // output register
  logic              out_valid_r;
  logic              out_kind_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic              out_stopped_r;
  logic              out_last_r;

  logic [6:0]        slot_ext;
  logic              slot_ok;
  logic [IDX_W-1:0]  slot_idx;
  logic [6:0]        hold_ext;
  logic [TIME_W-1:0] dl_q, rl_q;
  logic              hit;
  logic              out_free;
  logic              is_init, is_arm, is_start, is_stop, is_query, is_tick, is_check;
  logic              dl_we, rl_we;
  logic [IDX_W-1:0]  dl_waddr;
  logic [TIME_W-1:0] dl_wdata;
  logic              push;
  logic              push_kind, push_stopped, push_last;
  logic [SLOT_W-1:0] push_slot;

  // slot decode
  assign slot_ext = {3'b000, cmd_slot_r};
  assign slot_ok  = (slot_ext < 7'(NUM_SLOTS));
  assign slot_idx = slot_ext[IDX_W-1:0];
  assign hold_ext = 7'(hold_r);

  always_comb begin
    is_init  = 1'b0;
    is_start = 1'b0;
    is_stop  = 1'b0;
    is_arm   = 1'b0;
    is_query = 1'b0;
    is_tick  = 1'b0;
    is_check = 1'b0;
    unique case (cmd_kind_r)
      KIND_INIT:  is_init  = cmd.exec;
      KIND_START: is_start = cmd.exec;
      KIND_STOP:  is_stop  = cmd.exec;
      KIND_ARM:   is_arm   = cmd.exec;
      KIND_QUERY: is_query = cmd.exec;
      KIND_TICK:  is_tick  = cmd.exec;
      KIND_CHECK: is_check = cmd.exec;
      default: ;
    endcase
  end

  // scanned slot: entries never written read as zero
  assign dl_q     = dl_vld_r[idx_r] ? dl_rd_r : '0;
  assign rl_q     = rl_vld_r[idx_r] ? rl_rd_r : '0;
  assign hit      = reg_r[idx_r] & act_r[idx_r] & (dl_q <= now_r);
  assign out_free = !out_valid_r || out_ready;

  // table write ports
  assign rl_we    = (is_init || is_arm) && slot_ok;
  assign dl_we    = rl_we || (cmd.step && hit && per_r[idx_r]);
  assign dl_waddr = cmd.step ? idx_r : slot_idx;
  assign dl_wdata = now_r + (cmd.step ? rl_q : cmd_period_r);

  always_ff @(posedge clk) begin
    if (dl_we) begin
      dl_mem[dl_waddr] <= dl_wdata;
    end
    if (rl_we) begin
      rl_mem[slot_idx] <= cmd_period_r;
    end
    if (cmd.rd) begin
      dl_rd_r <= dl_mem[idx_r];
      rl_rd_r <= rl_mem[idx_r];
    end
  end

  // capture the input beat
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      cmd_kind_r   <= in_kind;
      cmd_slot_r   <= in_slot;
      cmd_period_r <= in_period;
      cmd_flags_r  <= in_init_flags;
      cmd_rep_r    <= in_repeat_req;
    end
  end

  // time count, flags and valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r    <= '0;
      act_r    <= '0;
      per_r    <= '0;
      reg_r    <= '0;
      dl_vld_r <= '0;
      rl_vld_r <= '0;
    end else begin
      if (is_tick) begin
        now_r <= now_r + 1'b1;
      end
      if (dl_we) begin
        dl_vld_r[dl_waddr] <= 1'b1;
      end
      if (rl_we) begin
        rl_vld_r[slot_idx] <= 1'b1;
      end
      if (slot_ok) begin
        if (is_init) begin
          act_r[slot_idx] <= cmd_flags_r[0];
          per_r[slot_idx] <= cmd_flags_r[1];
        end
        if (is_start || is_arm) begin
          reg_r[slot_idx] <= 1'b1;
          act_r[slot_idx] <= 1'b1;
        end
        if (is_arm) begin
          per_r[slot_idx] <= cmd_rep_r;
        end
        if (is_stop && reg_r[slot_idx]) begin
          act_r[slot_idx] <= 1'b0;
        end
      end
      // one-shot slot deactivates on expiry
      if (cmd.step && hit && !per_r[idx_r]) begin
        act_r[idx_r] <= 1'b0;
      end
    end
  end

  // scan index and held expiry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
    end else begin
      if (is_check || cmd.flush) begin
        hold_vld_r <= 1'b0;
      end else if (cmd.step && hit) begin
        hold_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_check) begin
      idx_r <= '0;
    end else if (cmd.step) begin
      idx_r <= idx_r + 1'b1;
      if (hit) begin
        hold_r <= idx_r;
      end
    end
  end

  // result selection
  always_comb begin
    push         = 1'b0;
    push_kind    = RES_EXPIRY;
    push_slot    = hold_ext[SLOT_W-1:0];
    push_stopped = 1'b0;
    push_last    = 1'b0;
    if (is_query) begin
      push         = 1'b1;
      push_kind    = RES_QUERY;
      push_slot    = cmd_slot_r;
      push_stopped = !slot_ok || !act_r[slot_idx];
      push_last    = 1'b1;
    end else if (cmd.step && hit && hold_vld_r) begin
      push = 1'b1;
    end else if (cmd.flush && hold_vld_r) begin
      push      = 1'b1;
      push_last = 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_kind_r    <= push_kind;
      out_slot_r    <= push_slot;
      out_stopped_r <= push_stopped;
      out_last_r    <= push_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_result_slot = out_slot_r;
  assign out_stopped     = out_stopped_r;
  assign out_last        = out_last_r;

  // status to the controller
  assign stat.kind     = cmd_kind_r;
  assign stat.out_free = out_free;
  assign stat.hit      = hit;
  assign stat.hold_vld = hold_vld_r;
  assign stat.idx_last = (idx_r == IDX_W'(NUM_SLOTS - 1));

endmodule

// ----- rtl/core/multi_slot_timer_table.sv -----
// Multi-slot timer table. Commands arrive one beat at a time on in_ch and
// results leave on out_ch through a one-entry output register, so a new
// command is taken while a result still waits. Init, start, stop, arm and
// tick pass through accept and execute; a query also waits for room in
// the output register before execute. A check walks the slots one at a
// time through the single read port of the deadline and reload memories,
// a read and an evaluate step per slot, through accept, execute, the walk
// and a final flush, with stalls under output back-pressure; expiries come out
// in ascending slot order with last set on the final one. Reset clears
// the time count and all slot state at once (valid bits stand in for the
// cleared memories), so there is no clearing pass after reset.
// Depends on mstt_pkg, mstt_if, mstt_ctrl and mstt_dpath.
module multi_slot_timer_table #(
  parameter int NUM_SLOTS = 16
) (
  input logic        clk,
  input logic        rst_n,
  mstt_in_if.sink    in_ch,
  mstt_out_if.source out_ch
);
  import mstt_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // controller
  mstt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  mstt_dpath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_kind         (in_ch.kind),
    .in_slot         (in_ch.slot),
    .in_period       (in_ch.period),
    .in_init_flags   (in_ch.init_flags),
    .in_repeat_req   (in_ch.repeat_req),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_result_kind (out_ch.result_kind),
    .out_result_slot (out_ch.result_slot),
    .out_stopped     (out_ch.stopped),
    .out_last        (out_ch.last)
  );

endmodule

// ----- rtl/core/mstt_checker.sv -----
// port-level assertions for the multi-slot timer table
// depends on mstt_pkg; attached to multi_slot_timer_table by the bind below
module mstt_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_result_kind,
  input logic [mstt_pkg::SLOT_W-1:0] out_result_slot,
  input logic                        out_stopped,
  input logic                        out_last
);
  import mstt_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_kind)
      && $stable(out_result_slot) && $stable(out_stopped) && $stable(out_last))
    else $error("result beat changed while stalled");

  // each accepted command is executed before the next is taken
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a command is in flight");

  // expiry results never report stopped
  a_expiry_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == RES_EXPIRY |-> !out_stopped)
    else $error("expiry result with stopped set");

  // a query reply is always the final result of its command
  a_query_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == RES_QUERY |-> out_last)
    else $error("query reply without last");

  // nothing leaves right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind multi_slot_timer_table mstt_checker u_mstt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_result_kind (out_ch.result_kind),
  .out_result_slot (out_ch.result_slot),
  .out_stopped     (out_ch.stopped),
  .out_last        (out_ch.last)
);

// ----- tb/sv/multi_slot_timer_table_chk.sv -----
// result checker for the multi-slot timer table testbench
// watches both channels, keeps its own copy of the slot table and compares
// every result beat; depends on mstt_pkg and mstt_if
module multi_slot_timer_table_chk #(
  parameter int NUM_SLOTS = 16
) (
  input  logic clk,
  input  logic rst_n,
  mstt_in_if   in_ch,
  mstt_out_if  out_ch,
  output int   fail_count,
  output int   pending
);
  import mstt_pkg::*;

  typedef struct packed {
    logic              rkind;
    logic [SLOT_W-1:0] slot;
    logic              stopped;
    logic              last;
  } timer_result_t;

  // predicted timer table
  logic [TIME_W-1:0] now_ticks;
  logic [TIME_W-1:0] due_time  [NUM_SLOTS];
  logic [TIME_W-1:0] period_of [NUM_SLOTS];
  logic              is_active [NUM_SLOTS];
  logic              is_periodic [NUM_SLOTS];
  logic              is_registered [NUM_SLOTS];

  timer_result_t expected_results[$];

  // apply one accepted command to the table and queue the results it causes
  task automatic apply_timer_cmd(input logic [KIND_W-1:0] kind,
                                 input logic [SLOT_W-1:0] slot,
                                 input logic [TIME_W-1:0] period,
                                 input logic [FLAGS_W-1:0] flags,
                                 input logic rep);
    logic          in_range;
    logic [63:0]   expired;
    int            last_hit;
    timer_result_t res;
    in_range = int'(slot) < NUM_SLOTS;
    expired  = '0;
    last_hit = -1;
    case (kind)
      KIND_INIT: begin
        if (in_range) begin
          period_of[slot]   = period;
          due_time[slot]    = now_ticks + period;
          is_active[slot]   = flags[0];
          is_periodic[slot] = flags[1];
        end
      end
      KIND_START: begin
        if (in_range) begin
          is_registered[slot] = 1'b1;
          is_active[slot]     = 1'b1;
        end
      end
      KIND_STOP: begin
        if (in_range && is_registered[slot]) is_active[slot] = 1'b0;
      end
      KIND_ARM: begin
        if (in_range) begin
          period_of[slot]     = period;
          due_time[slot]      = now_ticks + period;
          is_periodic[slot]   = rep;
          is_registered[slot] = 1'b1;
          is_active[slot]     = 1'b1;
        end
      end
      KIND_QUERY: begin
        res.rkind   = RES_QUERY;
        res.slot    = slot;
        res.stopped = in_range ? !is_active[slot] : 1'b1;
        res.last    = 1'b1;
        expected_results.push_back(res);
      end
      KIND_TICK: begin
        now_ticks = now_ticks + 1'b1;
      end
      KIND_CHECK: begin
        // find the expired slots first so the final one can carry last
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (is_registered[i] && is_active[i] && due_time[i] <= now_ticks) begin
            expired[i] = 1'b1;
            last_hit   = i;
          end
        end
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (expired[i]) begin
            if (is_periodic[i]) due_time[i] = now_ticks + period_of[i];
            else is_active[i] = 1'b0;
            res.rkind   = RES_EXPIRY;
            res.slot    = i[SLOT_W-1:0];
            res.stopped = 1'b0;
            res.last    = (i == last_hit);
            expected_results.push_back(res);
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic compare_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $display("%0t: result %s mismatch, expected %0d, actual %0d",
               $time, name, exp_val, act_val);
      fail_count++;
    end
  endtask

  // sample both channels at the rising edge
  always @(posedge clk) begin
    timer_result_t want;
    if (!rst_n) begin
      now_ticks = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        due_time[i]      = '0;
        period_of[i]     = '0;
        is_active[i]     = 1'b0;
        is_periodic[i]   = 1'b0;
        is_registered[i] = 1'b0;
      end
      expected_results.delete();
    end else begin
      if (in_ch.valid && in_ch.ready)
        apply_timer_cmd(in_ch.kind, in_ch.slot, in_ch.period, in_ch.init_flags,
                        in_ch.repeat_req);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual kind=%0d slot=%0d",
                   $time, out_ch.result_kind, out_ch.result_slot);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          compare_field("kind", int'(want.rkind), int'(out_ch.result_kind));
          compare_field("slot", int'(want.slot), int'(out_ch.result_slot));
          compare_field("stopped", int'(want.stopped), int'(out_ch.stopped));
          compare_field("last", int'(want.last), int'(out_ch.last));
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

// ----- tb/sv/multi_slot_timer_table_tb.sv -----
// top of the multi-slot timer table testbench: clock, reset, command
// stimulus with random gaps and result back-pressure, and the verdict
// depends on mstt_pkg, mstt_if, multi_slot_timer_table_chk and the block
module multi_slot_timer_table_tb;
  import mstt_pkg::*;

  localparam int NUM_SLOTS = 16;
  localparam int NUM_CMDS  = 380;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

  logic clk = 1'b0;
  logic rst_n;
  logic calm = 1'b0;
  int   fail_count;
  int   pending;

  mstt_in_if  in_ch ();
  mstt_out_if out_ch ();

  multi_slot_timer_table #(.NUM_SLOTS(NUM_SLOTS)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  multi_slot_timer_table_chk #(.NUM_SLOTS(NUM_SLOTS)) chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #6 clk = ~clk;

  // hard stop in case the block hangs
  initial begin
    #6000000;
    $display("Regression FAIL");
    $finish;
  end

  // mostly short periods so deadlines come due, some that wrap, some wide
  function automatic logic [TIME_W-1:0] pick_period();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return $urandom_range(0, 6);
    else if (sel < 8) return 32'hFFFF_FFFF - $urandom_range(0, 8);
    else return $urandom;
  endfunction

  // one command beat, called at a falling edge and returning at one
  task automatic send_cmd(input logic [KIND_W-1:0] kind,
                          input logic [SLOT_W-1:0] slot,
                          input logic [TIME_W-1:0] period,
                          input logic [FLAGS_W-1:0] flags,
                          input logic rep);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= kind;
    in_ch.slot       <= slot;
    in_ch.period     <= period;
    in_ch.init_flags <= flags;
    in_ch.repeat_req <= rep;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // result side: random stall before each beat
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // command stimulus
  initial begin
    int sent;
    int pick;
    logic [KIND_W-1:0] kind;
    in_ch.valid      = 1'b0;
    in_ch.kind       = KIND_INIT;
    in_ch.slot       = '0;
    in_ch.period     = '0;
    in_ch.init_flags = '0;
    in_ch.repeat_req = 1'b0;
    rst_n            = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty table, unused kind, stop of an unregistered slot
    send_cmd(KIND_QUERY, 4'd0, '0, 2'b00, 1'b0);
    send_cmd(KIND_CHECK, 4'd0, '0, 2'b00, 1'b0);
    send_cmd(KIND_UNUSED, 4'd9, 32'hFFFF_FFFF, 2'b11, 1'b1);
    send_cmd(KIND_INIT, 4'd3, 32'd0, 2'b01, 1'b0);
    send_cmd(KIND_STOP, 4'd3, '0, 2'b00, 1'b0);
    send_cmd(KIND_QUERY, 4'd3, '0, 2'b00, 1'b0);
    send_cmd(KIND_CHECK, 4'd0, '0, 2'b00, 1'b0);
    // one-shot expiry once registered
    send_cmd(KIND_START, 4'd3, '0, 2'b00, 1'b0);
    send_cmd(KIND_CHECK, 4'd0, '0, 2'b00, 1'b0);
    send_cmd(KIND_QUERY, 4'd3, '0, 2'b00, 1'b0);
    // wrapped deadline expires at once, periodic reloads
    send_cmd(KIND_TICK, 4'd0, '0, 2'b00, 1'b0);
    send_cmd(KIND_ARM, 4'd15, 32'hFFFF_FFFF, 2'b00, 1'b1);
    send_cmd(KIND_ARM, 4'd0, 32'd1, 2'b00, 1'b0);
    send_cmd(KIND_INIT, 4'd7, 32'd0, 2'b11, 1'b0);
    send_cmd(KIND_START, 4'd7, '0, 2'b00, 1'b0);
    send_cmd(KIND_CHECK, 4'd0, '0, 2'b00, 1'b0);
    send_cmd(KIND_TICK, 4'd0, '0, 2'b00, 1'b0);
    send_cmd(KIND_CHECK, 4'd0, '0, 2'b00, 1'b0);
    // arm with one-shot clears periodic, init with active clear
    send_cmd(KIND_ARM, 4'd15, 32'd0, 2'b00, 1'b0);
    send_cmd(KIND_INIT, 4'd7, 32'h8000_0000, 2'b10, 1'b0);
    send_cmd(KIND_CHECK, 4'd0, '0, 2'b00, 1'b0);
    send_cmd(KIND_STOP, 4'd7, '0, 2'b00, 1'b0);
    send_cmd(KIND_QUERY, 4'd7, '0, 2'b00, 1'b0);
    send_cmd(KIND_QUERY, 4'd15, '0, 2'b00, 1'b0);

    // random commands, now and then every slot armed in turn before a check
    sent = 0;
    while (sent < NUM_CMDS) begin
      if ($urandom_range(0, 29) == 0) calm = !calm;
      if ($urandom_range(0, 59) == 0) begin
        for (int s = 0; s < NUM_SLOTS; s++)
          send_cmd(KIND_ARM, s[SLOT_W-1:0], $urandom_range(0, 2),
                   FLAGS_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        send_cmd(KIND_CHECK, SLOT_W'($urandom_range(0, 15)), pick_period(),
                 FLAGS_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        sent += NUM_SLOTS + 1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 10) kind = KIND_INIT;
        else if (pick < 18) kind = KIND_START;
        else if (pick < 26) kind = KIND_STOP;
        else if (pick < 41) kind = KIND_ARM;
        else if (pick < 51) kind = KIND_QUERY;
        else if (pick < 75) kind = KIND_TICK;
        else if (pick < 96) kind = KIND_CHECK;
        else kind = KIND_UNUSED;
        send_cmd(kind, SLOT_W'($urandom_range(0, 15)), pick_period(),
                 FLAGS_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        if (kind != KIND_UNUSED) sent++;
      end
    end
    in_ch.valid <= 1'b0;

    // drain, then give a full scan time for stray beats
    while (pending != 0) @(negedge clk);
    repeat (2 * NUM_SLOTS + 10) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/mstt_pkg.sv
rtl/core/mstt_if.sv
rtl/core/mstt_ctrl.sv
rtl/core/mstt_dpath.sv
rtl/core/multi_slot_timer_table.sv
rtl/core/mstt_checker.sv
tb/sv/multi_slot_timer_table_chk.sv
tb/sv/multi_slot_timer_table_tb.sv
